// ===== rtl/core/osm_pkg.sv =====
// Shared types and codes for the order-statistic multiset.
// No dependencies; the cell, controller, top level and testbench refer to it by scoped names.
package osm_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_NONE   = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        STS_DONE = 2'd0,
        STS_FULL = 2'd1,
        STS_RANK = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic ins;   // open a slot above the new key and fill it
        logic del;   // pull every entry at or above the key one place down
    } cell_cmd_t;

endpackage

// ===== rtl/core/osm_req_if.sv =====
// Request channel: action, value and rank with a valid/ready handshake.
// Depends on nothing; widths are set by the instantiating level.
interface osm_req_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_W     = 9
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]            rank;

    modport source (output valid, output action, output value, output rank, input ready);
    modport sink   (input valid, input action, input value, input rank, output ready);
endinterface

// ===== rtl/core/osm_rsp_if.sv =====
// Response channel: found value, status and stored count with valid/ready.
// Depends on nothing; widths are set by the instantiating level.
interface osm_rsp_if #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_W     = 9
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] found_value;
    logic [1:0]                    status;
    logic [COUNT_W-1:0]            stored_count;

    modport source (output valid, output found_value, output status, output stored_count,
                    input ready);
    modport sink   (input valid, input found_value, input status, input stored_count,
                    output ready);
endinterface

// ===== rtl/core/osm_cell.sv =====
// One storage cell of the sorted chain: holds a value and shifts with neighbours.
// Depends on osm_pkg (cell_cmd_t).
module osm_cell #(
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_W     = 9,
    parameter int INDEX       = 0
) (
    input  logic                          clk,
    input  osm_pkg::cell_cmd_t            cmd,
    input  logic signed [VALUE_WIDTH-1:0] key,
    input  logic [COUNT_W-1:0]            count,
    input  logic signed [VALUE_WIDTH-1:0] left_val,
    input  logic                          left_gt,
    input  logic signed [VALUE_WIDTH-1:0] right_val,
    output logic signed [VALUE_WIDTH-1:0] val,
    output logic                          gt,
    output logic                          eq
);

    logic signed [VALUE_WIDTH-1:0] val_reg;
    logic                          occ;

    // Entries below the count are held; the rest are free
    assign occ = COUNT_W'(INDEX) < count;
    assign gt  = occ && (val_reg > key);
    assign eq  = occ && (val_reg == key);
    assign val = val_reg;

    // Free cells may take junk; they are never read before being filled
    always_ff @(posedge clk)
    begin
        if (cmd.ins && (gt || !occ))
        begin
            val_reg <= left_gt ? left_val : key;
        end
        else if (cmd.del && (gt || eq || !occ))
        begin
            val_reg <= right_val;
        end
    end

endmodule

// ===== rtl/core/osm_ctrl.sv =====
// Sequencer for the multiset: decodes items, drives the cell chain, holds the
// element count and the result register. Depends on osm_pkg and both channel interfaces.
module osm_ctrl #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32,
    parameter int COUNT_W     = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    osm_req_if.sink                       req,
    osm_rsp_if.source                     rsp,
    input  logic                          any_eq,
    input  logic signed [VALUE_WIDTH-1:0] tap_val,
    output osm_pkg::cell_cmd_t            cmd,
    output logic signed [VALUE_WIDTH-1:0] key,
    output logic [COUNT_W-1:0]            count,
    output logic [COUNT_W-1:0]            target
);

    osm_pkg::state_t               state_reg, state_next;
    osm_pkg::act_t                 action_reg, action_next;
    osm_pkg::status_t              status_reg, status_next;
    logic signed [VALUE_WIDTH-1:0] key_reg, key_next;
    logic [COUNT_W-1:0]            target_reg, target_next;
    logic [COUNT_W-1:0]            count_reg, count_next;
    logic                          res_valid_reg, res_valid_next;
    logic signed [VALUE_WIDTH-1:0] res_found_reg, res_found_next;
    osm_pkg::status_t              res_status_reg, res_status_next;
    logic [COUNT_W-1:0]            res_count_reg, res_count_next;
    logic                          slot_free;
    logic                          accept;
    logic                          finish;

    assign req.ready        = (state_reg == osm_pkg::ST_IDLE);
    assign accept           = req.valid && req.ready;
    assign slot_free        = !res_valid_reg || rsp.ready;
    assign rsp.valid        = res_valid_reg;
    assign rsp.found_value  = res_found_reg;
    assign rsp.status       = res_status_reg;
    assign rsp.stored_count = res_count_reg;
    assign key              = key_reg;
    assign count            = count_reg;
    assign target           = target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= osm_pkg::ST_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        status_reg     <= status_next;
        key_reg        <= key_next;
        target_reg     <= target_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        action_next     = action_reg;
        status_next     = status_reg;
        key_next        = key_reg;
        target_next     = target_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg && !rsp.ready;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        cmd             = '0;
        finish          = 1'b0;

        unique case (state_reg)
            osm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    action_next = osm_pkg::act_t'(req.action);
                    key_next    = req.value;
                    target_next = count_reg - req.rank;
                    status_next = osm_pkg::STS_DONE;
                    if (action_next == osm_pkg::ACT_INSERT
                        && count_reg == COUNT_W'(CAPACITY))
                    begin
                        status_next = osm_pkg::STS_FULL;
                    end
                    else if (action_next == osm_pkg::ACT_QUERY
                             && (req.rank == '0 || req.rank > count_reg))
                    begin
                        status_next = osm_pkg::STS_RANK;
                    end
                    state_next = osm_pkg::ST_EXEC;
                end
            end
            osm_pkg::ST_EXEC:
            begin
                res_found_next = '0;
                unique case (action_reg)
                    osm_pkg::ACT_INSERT:
                    begin
                        if (slot_free)
                        begin
                            finish = 1'b1;
                            if (status_reg == osm_pkg::STS_DONE)
                            begin
                                cmd.ins    = 1'b1;
                                count_next = count_reg + COUNT_W'(1);
                            end
                        end
                    end
                    osm_pkg::ACT_ERASE:
                    begin
                        // one copy leaves the chain per cycle
                        if (any_eq)
                        begin
                            cmd.del    = 1'b1;
                            count_next = count_reg - COUNT_W'(1);
                        end
                        else if (slot_free)
                        begin
                            finish = 1'b1;
                        end
                    end
                    osm_pkg::ACT_QUERY:
                    begin
                        if (slot_free)
                        begin
                            finish = 1'b1;
                            if (status_reg == osm_pkg::STS_DONE)
                            begin
                                res_found_next = tap_val;
                            end
                        end
                    end
                    default:
                    begin
                        finish = slot_free;
                    end
                endcase

                if (finish)
                begin
                    res_valid_next  = 1'b1;
                    res_status_next = status_reg;
                    res_count_next  = count_next;
                    state_next      = osm_pkg::ST_IDLE;
                end
                else
                begin
                    res_found_next = res_found_reg;
                end
            end
            default:
            begin
                state_next = osm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/order_statistic_multiset.sv =====
// Sorted multiset of signed values held in a chain of compare-and-shift cells.
// Insert and query: the result is registered once the register is free; no new item is taken before then.
// Erase: the chain drops one copy per cycle until none is left, then the result is registered.
// A waiting result does not block the next item; the next result waits for the register.
// Reset clears the element count and the handshake state; cell contents are not reset.
module order_statistic_multiset #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    osm_req_if.sink   req,
    osm_rsp_if.source rsp
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    osm_pkg::cell_cmd_t            cmd;
    logic signed [VALUE_WIDTH-1:0] key;
    logic [COUNT_W-1:0]            count;
    logic [COUNT_W-1:0]            target;
    logic signed [VALUE_WIDTH-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]           cell_gt;
    logic [CAPACITY-1:0]           cell_eq;
    logic                          any_eq;
    logic signed [VALUE_WIDTH-1:0] tap_val;

    osm_ctrl #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_W     (COUNT_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .any_eq  (any_eq),
        .tap_val (tap_val),
        .cmd     (cmd),
        .key     (key),
        .count   (count),
        .target  (target)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic signed [VALUE_WIDTH-1:0] left_val;
        logic                          left_gt;
        logic signed [VALUE_WIDTH-1:0] right_val;

        if (g == 0)
        begin : g_first
            assign left_val = key;
            assign left_gt  = 1'b0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[g-1];
            assign left_gt  = cell_gt[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign right_val = key;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[g+1];
        end

        osm_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .COUNT_W     (COUNT_W),
            .INDEX       (g)
        ) u_cell (
            .clk       (clk),
            .cmd       (cmd),
            .key       (key),
            .count     (count),
            .left_val  (left_val),
            .left_gt   (left_gt),
            .right_val (right_val),
            .val       (cell_val[g]),
            .gt        (cell_gt[g]),
            .eq        (cell_eq[g])
        );
    end

    assign any_eq = |cell_eq;

    // k-th largest sits at index count - k; the matching cell drives an OR tree
    always_comb
    begin
        tap_val = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (COUNT_W'(i) == target)
            begin
                tap_val = tap_val | cell_val[i];
            end
        end
    end

endmodule

// ===== dv/order_statistic_multiset_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for order_statistic_multiset: directed table, then random traffic.
// Depends on osm_pkg, osm_req_if, osm_rsp_if and the order_statistic_multiset RTL.
module order_statistic_multiset_test;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = 9;
    localparam int RANK_MAX    = (1 << COUNT_W) - 1;

    localparam logic signed [VALUE_WIDTH-1:0] MAX_VAL = 32'sh7fff_ffff;
    localparam logic signed [VALUE_WIDTH-1:0] MIN_VAL = 32'sh8000_0000;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] found;
        osm_pkg::status_t              status;
        logic [COUNT_W-1:0]            count;
    } osm_result_t;

    typedef struct packed {
        osm_pkg::act_t                 act;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [COUNT_W-1:0]            rank;
        logic                          typed;
        logic signed [VALUE_WIDTH-1:0] found;
        osm_pkg::status_t              status;
        logic [COUNT_W-1:0]            count;
    } dir_row_t;

    localparam int N_DIRECTED = 23;

    // typed = 1: expected result is given in the row, else it comes from the predictor
    dir_row_t directed_rows [0:N_DIRECTED-1] = '{
        '{osm_pkg::ACT_QUERY,  32'sd0,  9'd1,   1'b1, 32'sd0,  osm_pkg::STS_RANK, 9'd0},
        '{osm_pkg::ACT_ERASE,  32'sd5,  9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_NONE,   32'sd0,  9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_INSERT, MAX_VAL, 9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd1},
        '{osm_pkg::ACT_INSERT, MIN_VAL, 9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd2},
        '{osm_pkg::ACT_QUERY,  32'sd0,  9'd1,   1'b1, MAX_VAL, osm_pkg::STS_DONE, 9'd2},
        '{osm_pkg::ACT_QUERY,  MAX_VAL, 9'd2,   1'b1, MIN_VAL, osm_pkg::STS_DONE, 9'd2},
        '{osm_pkg::ACT_QUERY,  32'sd0,  9'd0,   1'b1, 32'sd0,  osm_pkg::STS_RANK, 9'd2},
        '{osm_pkg::ACT_QUERY,  32'sd0,  9'd3,   1'b1, 32'sd0,  osm_pkg::STS_RANK, 9'd2},
        '{osm_pkg::ACT_QUERY,  MIN_VAL, 9'd511, 1'b1, 32'sd0,  osm_pkg::STS_RANK, 9'd2},
        '{osm_pkg::ACT_INSERT, 32'sd0,  9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd3},
        '{osm_pkg::ACT_INSERT, 32'sd0,  9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd4},
        '{osm_pkg::ACT_INSERT, -32'sd1, 9'd0,   1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd5},
        '{osm_pkg::ACT_INSERT, 32'sd0,  9'd511, 1'b1, 32'sd0,  osm_pkg::STS_DONE, 9'd6},
        '{osm_pkg::ACT_QUERY,  -32'sd1, 9'd3,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_ERASE,  32'sd0,  9'd0,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_ERASE,  MAX_VAL, 9'd1,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_QUERY,  32'sd0,  9'd1,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_NONE,   MAX_VAL, 9'd511, 1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_ERASE,  -32'sd7, 9'd0,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_ERASE,  MIN_VAL, 9'd0,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_ERASE,  -32'sd1, 9'd0,   1'b0, 32'sd0,  osm_pkg::STS_DONE, 9'd0},
        '{osm_pkg::ACT_QUERY,  32'sd0,  9'd1,   1'b1, 32'sd0,  osm_pkg::STS_RANK, 9'd0}
    };

    logic clk;
    logic rst_n;

    osm_req_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_W(COUNT_W)) req_ch ();
    osm_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_W(COUNT_W)) rsp_ch ();

    order_statistic_multiset #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Mirror of the store, ascending, duplicates kept
    logic signed [VALUE_WIDTH-1:0] held_values [$];
    osm_result_t                   pending_results [$];
    int                            error_count = 0;
    bit                            no_idle = 1'b0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic osm_result_t apply_item(osm_pkg::act_t act,
                                               logic signed [VALUE_WIDTH-1:0] value,
                                               logic [COUNT_W-1:0] rank);
        osm_result_t res;
        int          pos;
        res.found  = '0;
        res.status = osm_pkg::STS_DONE;
        case (act)
            osm_pkg::ACT_INSERT:
            begin
                if (held_values.size() >= CAPACITY)
                    res.status = osm_pkg::STS_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_values.size() && held_values[pos] <= value)
                        pos++;
                    held_values.insert(pos, value);
                end
            end
            osm_pkg::ACT_ERASE:
            begin
                for (int i = held_values.size() - 1; i >= 0; i--)
                    if (held_values[i] == value)
                        held_values.delete(i);
            end
            osm_pkg::ACT_QUERY:
            begin
                if (rank == 0 || rank > held_values.size())
                    res.status = osm_pkg::STS_RANK;
                else
                    res.found = held_values[held_values.size() - rank];
            end
            default: ;
        endcase
        res.count = COUNT_W'(held_values.size());
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    // Mostly a narrow pool so that duplicates and erase hits are common
    function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return int'($urandom_range(0, 15)) - 8;
        else if (r < 85)
            return $urandom;
        else
        begin
            case ($urandom_range(0, 3))
                0: return MIN_VAL;
                1: return MIN_VAL + 1;
                2: return MAX_VAL - 1;
                default: return MAX_VAL;
            endcase
        end
    endfunction

    function automatic logic signed [VALUE_WIDTH-1:0] pick_present();
        if (held_values.size() > 0 && $urandom_range(0, 99) < 70)
            return held_values[$urandom_range(0, held_values.size() - 1)];
        return pick_value();
    endfunction

    function automatic logic [COUNT_W-1:0] pick_rank();
        if (held_values.size() > 0 && $urandom_range(0, 99) < 80)
            return COUNT_W'($urandom_range(1, held_values.size()));
        return COUNT_W'($urandom_range(0, RANK_MAX));
    endfunction

    task automatic send_item(input osm_pkg::act_t act,
                             input logic signed [VALUE_WIDTH-1:0] value,
                             input logic [COUNT_W-1:0] rank, input bit typed,
                             input osm_result_t typed_res);
        int          gap;
        osm_result_t res;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= value;
        req_ch.rank   <= rank;
        do
            @(posedge clk);
        while (!req_ch.ready);
        res = apply_item(act, value, rank);
        pending_results = {pending_results, (typed ? typed_res : res)};
    endtask

    // Receiver back-pressure: runs of ready high or low of random length
    initial
    begin
        int   run;
        int   r;
        logic level;
        rsp_ch.ready <= 1'b0;
        run = 0;
        level = 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    level = 1'b0;
                    run = $urandom_range(8, 40);
                end
                else if (r < 40)
                begin
                    level = 1'b0;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    level = 1'b1;
                    run = $urandom_range(1, 20);
                end
            end
            rsp_ch.ready <= no_idle ? 1'b1 : level;
            run--;
        end
    end

    always @(posedge clk)
    begin : check_result
        osm_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got found %0d status %0d count %0d",
                         $time, rsp_ch.found_value, rsp_ch.status, rsp_ch.stored_count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.found_value !== want.found)
                begin
                    $display("%0t: found_value expected %0d, got %0d",
                             $time, want.found, rsp_ch.found_value);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.stored_count !== want.count)
                begin
                    $display("%0t: stored_count expected %0d, got %0d",
                             $time, want.count, rsp_ch.stored_count);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("order_statistic_multiset: mismatch");
        $finish;
    end

    initial
    begin
        int          i;
        int          r;
        osm_result_t row_res;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.action <= osm_pkg::ACT_NONE;
        req_ch.value  <= '0;
        req_ch.rank   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            row_res.found  = directed_rows[i].found;
            row_res.status = directed_rows[i].status;
            row_res.count  = directed_rows[i].count;
            send_item(directed_rows[i].act, directed_rows[i].value, directed_rows[i].rank,
                      directed_rows[i].typed, row_res);
        end

        // Mixed traffic with a back-to-back stretch in the middle
        for (i = 0; i < 100; i++)
        begin
            no_idle = (i >= 30 && i < 60);
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(osm_pkg::ACT_INSERT, pick_value(), COUNT_W'($urandom), 1'b0, '0);
            else if (r < 60)
                send_item(osm_pkg::ACT_ERASE, pick_present(), COUNT_W'($urandom), 1'b0, '0);
            else if (r < 95)
                send_item(osm_pkg::ACT_QUERY, $urandom, pick_rank(), 1'b0, '0);
            else
                send_item(osm_pkg::ACT_NONE, $urandom, COUNT_W'($urandom), 1'b0, '0);
        end
        no_idle = 1'b0;

        // Fill to capacity, queries mixed in
        while (held_values.size() < CAPACITY)
        begin
            if ($urandom_range(0, 99) < 10)
                send_item(osm_pkg::ACT_QUERY, $urandom, pick_rank(), 1'b0, '0);
            else
                send_item(osm_pkg::ACT_INSERT, pick_value(), COUNT_W'($urandom), 1'b0, '0);
        end

        // Full store: inserts dropped, ranks at and past the top
        for (i = 0; i < 3; i++)
            send_item(osm_pkg::ACT_INSERT, pick_value(), COUNT_W'($urandom), 1'b0, '0);
        send_item(osm_pkg::ACT_QUERY, $urandom, COUNT_W'(CAPACITY), 1'b0, '0);
        send_item(osm_pkg::ACT_QUERY, $urandom, COUNT_W'(CAPACITY + 1), 1'b0, '0);
        send_item(osm_pkg::ACT_QUERY, $urandom, COUNT_W'(RANK_MAX), 1'b0, '0);
        send_item(osm_pkg::ACT_QUERY, $urandom, COUNT_W'(1), 1'b0, '0);
        send_item(osm_pkg::ACT_NONE, $urandom, COUNT_W'($urandom), 1'b0, '0);
        send_item(osm_pkg::ACT_INSERT, MAX_VAL, COUNT_W'($urandom), 1'b0, '0);

        // Drain: mostly erases of held values
        i = 0;
        while (held_values.size() > 0)
        begin
            no_idle = (i < 15);
            r = $urandom_range(0, 99);
            if (r < 75)
                send_item(osm_pkg::ACT_ERASE,
                          held_values[$urandom_range(0, held_values.size() - 1)],
                          COUNT_W'($urandom), 1'b0, '0);
            else if (r < 95)
                send_item(osm_pkg::ACT_QUERY, $urandom, pick_rank(), 1'b0, '0);
            else
                send_item(osm_pkg::ACT_INSERT, pick_value(), COUNT_W'($urandom), 1'b0, '0);
            i++;
        end
        no_idle = 1'b0;
        send_item(osm_pkg::ACT_QUERY, $urandom, COUNT_W'(1), 1'b0, '0);
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (error_count == 0)
            $display("order_statistic_multiset: match");
        else
            $display("order_statistic_multiset: mismatch");
        $finish;
    end

endmodule
